@@ rtl/core/homlp_pkg.sv @@
// ----------------------------------------------------------------------------
// homlp_pkg
// Shared types and constants of the hashed object map with linear probing.
// ----------------------------------------------------------------------------
`default_nettype none

package homlp_pkg;

    localparam int KEY_W   = 48;
    localparam int IDX_W   = 10;
    localparam int TAG_W   = KEY_W + 1;
    // Hash bits carried from the front to the back; enough for the largest table.
    localparam int HASH_W  = 16;
    localparam int MIX_SHIFT = 33;

    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

    localparam logic [IDX_W-1:0] FILL_LIMIT_RESET = 10'd716;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        OP_FIND        = 1'b0,
        OP_FIND_INSERT = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
    } t_job;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

`default_nettype wire

@@ rtl/core/homlp_ram.sv @@
// ----------------------------------------------------------------------------
// homlp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module homlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/homlp_front.sv @@
// ----------------------------------------------------------------------------
// homlp_front
// Accepts lookup beats and computes the home slot hash in a five-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module homlp_front
    import homlp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic             i_op,
    input  wire t_back_stat       i_stat,
    output logic                  o_job_valid,
    output t_job                  o_job,
    input  wire logic             i_job_ready
);

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
    } t_item;

    logic        advance;
    logic        take;
    logic [63:0] v0;
    logic [63:0] m1;
    logic [63:0] m2;
    logic [63:0] h2;

    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    t_item       r_j1, r_j2, r_j3, r_j4, r_j5;
    logic [63:0] r_a1;
    logic [63:0] r_pll2;
    logic [31:0] r_phl2, r_plh2;
    logic [63:0] r_a3;
    logic [63:0] r_pll4;
    logic [31:0] r_phl4, r_plh4;
    logic [HASH_W-1:0] r_h5;

    logic [63:0] pll2, phl2, plh2, pll4, phl4, plh4;

    assign advance = !r_v5 || i_job_ready;
    assign o_ready = advance && !i_stat.clearing;
    assign take    = i_valid && o_ready;

    // The key is only 48 bits wide, so the first xor-shift folds its top 15 bits down.
    assign v0 = {16'd0, i_key} ^ {49'd0, i_key[KEY_W-1:MIX_SHIFT]};

    // 64-bit products modulo 2^64 from three 32 by 32 partial products.
    assign pll2 = {32'd0, r_a1[31:0]}  * {32'd0, MIX_C1[31:0]};
    assign phl2 = {32'd0, r_a1[63:32]} * {32'd0, MIX_C1[31:0]};
    assign plh2 = {32'd0, r_a1[31:0]}  * {32'd0, MIX_C1[63:32]};
    assign m1   = {r_pll2[63:32] + r_phl2 + r_plh2, r_pll2[31:0]};

    assign pll4 = {32'd0, r_a3[31:0]}  * {32'd0, MIX_C2[31:0]};
    assign phl4 = {32'd0, r_a3[63:32]} * {32'd0, MIX_C2[31:0]};
    assign plh4 = {32'd0, r_a3[31:0]}  * {32'd0, MIX_C2[63:32]};
    assign m2   = {r_pll4[63:32] + r_phl4 + r_plh4, r_pll4[31:0]};
    assign h2   = m2 ^ (m2 >> MIX_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (advance) begin
            r_v1 <= take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_j1   <= '{op: t_op'(i_op), key: i_key};
            r_a1   <= v0;
            r_j2   <= r_j1;
            r_pll2 <= pll2;
            r_phl2 <= phl2[31:0];
            r_plh2 <= plh2[31:0];
            r_j3   <= r_j2;
            r_a3   <= m1 ^ (m1 >> MIX_SHIFT);
            r_j4   <= r_j3;
            r_pll4 <= pll4;
            r_phl4 <= phl4[31:0];
            r_plh4 <= plh4[31:0];
            r_j5   <= r_j4;
            r_h5   <= h2[HASH_W-1:0];
        end
    end

    assign o_job_valid = r_v5;
    assign o_job       = '{op: r_j5.op, key: r_j5.key, hash: r_h5};

endmodule

`default_nettype wire

@@ rtl/core/homlp_queue.sv @@
// ----------------------------------------------------------------------------
// homlp_queue
// Short first-in first-out queue of hashed lookups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module homlp_queue
    import homlp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_job i_push_data,
    output logic      o_pop_valid,
    output t_job      o_pop_data,
    input  wire logic i_pop
);

    t_job                r_slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_data   = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/homlp_back.sv @@
// ----------------------------------------------------------------------------
// homlp_back
// Probe sequencer: clears the slot store, walks the probe run, inserts, replies.
// ----------------------------------------------------------------------------
`default_nettype none

module homlp_back
    import homlp_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_valid,
    input  wire t_job             i_job,
    output logic                  o_pop,
    output t_back_stat            o_stat,
    input  wire logic [IDX_W-1:0] i_fill_limit,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_status               o_status,
    output logic      [IDX_W-1:0] o_index
);

    localparam int SW     = $clog2(SLOTS);
    localparam int WORD_W = TAG_W + IDX_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_CHECK = 4'b0100,
        S_EMIT  = 4'b1000
    } t_back_state;

    t_back_state      r_state, n_state;
    logic [SW-1:0]    r_clr_addr, n_clr_addr;
    t_op              r_op, n_op;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [SW-1:0]    r_slot, n_slot;
    logic [SW-1:0]    r_probes, n_probes;
    logic [IDX_W-1:0] r_count, n_count;
    t_status          r_res_status, n_res_status;
    logic [IDX_W-1:0] r_res_index, n_res_index;
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    logic [IDX_W-1:0] r_out_index, n_out_index;

    logic              we;
    logic [SW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic [SW-1:0]     raddr;
    logic [WORD_W-1:0] rdata;
    logic [TAG_W-1:0]  rd_tag;
    logic [IDX_W-1:0]  rd_entry;
    logic [SW-1:0]     slot_next;
    logic              out_free;

    homlp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_tag    = rdata[WORD_W-1:IDX_W];
    assign rd_entry  = rdata[IDX_W-1:0];
    assign slot_next = r_slot + SW'(1);
    assign out_free  = !r_out_valid || i_ready;
    assign raddr     = (r_state == S_IDLE) ? i_job.hash[SW-1:0] : slot_next;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_op         = r_op;
        n_tag        = r_tag;
        n_slot       = r_slot;
        n_probes     = r_probes;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        o_pop        = 1'b0;
        we           = 1'b0;
        waddr        = r_slot;
        wdata        = {r_tag, n_count + IDX_W'(1)};

        case (r_state)
            S_CLEAR: begin
                we         = 1'b1;
                waddr      = r_clr_addr;
                wdata      = '0;
                n_clr_addr = r_clr_addr + SW'(1);
                if (r_clr_addr == {SW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop    = 1'b1;
                    n_op     = i_job.op;
                    n_tag    = {1'b0, i_job.key} + TAG_W'(1);
                    n_slot   = i_job.hash[SW-1:0];
                    n_probes = '0;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (rd_tag == r_tag) begin
                    n_res_status = ST_FOUND;
                    n_res_index  = rd_entry - IDX_W'(1);
                    n_state      = S_EMIT;
                end else if (rd_tag == '0) begin
                    n_res_index = '0;
                    n_state     = S_EMIT;
                    if (r_op == OP_FIND) begin
                        n_res_status = ST_NOT_FOUND;
                    end else if (r_count >= i_fill_limit) begin
                        n_res_status = ST_FULL;
                    end else begin
                        n_res_status = ST_INSERTED;
                        n_res_index  = r_count;
                        we           = 1'b1;
                        wdata        = {r_tag, r_count + IDX_W'(1)};
                        n_count      = r_count + IDX_W'(1);
                    end
                end else if (r_probes == {SW{1'b1}}) begin
                    n_res_index  = '0;
                    n_res_status = (r_op == OP_FIND) ? ST_NOT_FOUND : ST_FULL;
                    n_state      = S_EMIT;
                end else begin
                    n_slot   = slot_next;
                    n_probes = r_probes + SW'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_index  = r_res_index;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_tag        <= n_tag;
        r_slot       <= n_slot;
        r_probes     <= n_probes;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
    end

    assign o_stat   = '{clearing: (r_state == S_CLEAR)};
    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_index  = r_out_index;

endmodule

`default_nettype wire

@@ rtl/core/hashed_object_map_linear_probe.sv @@
// ----------------------------------------------------------------------------
// hashed_object_map_linear_probe
// Open-addressing map from a 48-bit record key to a dense entry index.
// ----------------------------------------------------------------------------
// Usage
// The slave stream carries one lookup per beat: the record key in tdata and
// the operation in tuser (find only, or find-or-insert). The master stream
// returns one beat per lookup, in order: the entry index in tdata and the
// status (found, inserted, not found, table full) in tuser. The user writes
// the fill limit register (i_cfg_we/i_cfg_wdata) only while idle, unenforced.
//
// A lookup passes through the hash pipeline and then waits at the head of the
// queue, where the back end issues the first slot read as it takes the lookup;
// after that it probes one slot after another and then loads the output
// register. The back end therefore finishes one lookup before it takes the
// next; the single read port of the slot memory keeps it to one probe at a
// time. Lookups keep entering the hash pipeline and queue while the back end
// works.
//
// After reset the back end sweeps the slot memory, one slot per cycle, over all
// SLOTS slots; s_axis_tready stays low meanwhile. If the receiver holds
// m_axis_tready low, the finished beat waits in the output register, the
// back end stalls in turn and the queue and front fill before tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_object_map_linear_probe
    import homlp_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Lookup stream.
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [47:0]      s_axis_tdata,  // [47:0] record_key
    input  wire logic             s_axis_tuser,  // [0] operation
    // Result stream.
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [15:0]      m_axis_tdata,  // [9:0] entry_index, [15:10] zero
    output logic      [1:0]       m_axis_tuser,  // [1:0] status
    // Fill limit register.
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_wdata
);

    logic [IDX_W-1:0] r_fill_limit;

    logic       job_valid;
    t_job       job;
    logic       job_ready;
    logic       q_valid;
    t_job       q_data;
    logic       q_pop;
    t_back_stat back_stat;
    t_status    status;
    logic [IDX_W-1:0] index;

    // The fill limit is the one register; it resets to 70 percent of 1023.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit <= FILL_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_fill_limit <= i_cfg_wdata;
        end
    end

    // Front end: accepts beats and hashes the key into a home slot.
    homlp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_key       (s_axis_tdata),
        .i_op        (s_axis_tuser),
        .i_stat      (back_stat),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    // The queue lets the hash pipeline run ahead of a long probe run.
    homlp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (job_valid),
        .o_push_ready (job_ready),
        .i_push_data  (job),
        .o_pop_valid  (q_valid),
        .o_pop_data   (q_data),
        .i_pop        (q_pop)
    );

    // Back end: probes the slot store and owns the output register.
    homlp_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (q_data),
        .o_pop        (q_pop),
        .o_stat       (back_stat),
        .i_fill_limit (r_fill_limit),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_status     (status),
        .o_index      (index)
    );

    assign m_axis_tdata = {6'd0, index};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire

@@ rtl/core/homlp_checker.sv @@
// ----------------------------------------------------------------------------
// homlp_checker
// Port-level checks of the hashed object map, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module homlp_checker
    import homlp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat present straight after reset");

    // The slot store sweep follows reset, so no lookup may be taken then.
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !s_axis_tready)
        else $error("lookup accepted during the clearing sweep");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // Misses and refusals carry a zero index.
    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND || m_axis_tuser == ST_FULL)
            |-> m_axis_tdata[9:0] == 10'd0)
        else $error("non-zero index on a miss or a full reply");

    // At most 1023 entries exist, so the all-ones index never appears.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:0] != 10'h3FF)
        else $error("entry index out of range");

endmodule

bind hashed_object_map_linear_probe homlp_checker u_homlp_checker (.*);

`default_nettype wire
